@@ src/jsu_pkg.sv @@
package jsu_pkg;

   // Result kinds carried on tuser
   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // Parser modes
   typedef enum logic [2:0] {
      MODE_WAIT    = 3'd0,
      MODE_BODY    = 3'd1,
      MODE_ESC     = 3'd2,
      MODE_HEX1    = 3'd3,
      MODE_PAIR_BS = 3'd4,
      MODE_PAIR_U  = 3'd5,
      MODE_HEX2    = 3'd6
   } mode_type;

   localparam int MaxResults = 4;
   localparam int ByteW      = 8;
   localparam int IdxW       = $clog2(MaxResults);

   // Character codes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [15:0] HI_SUR_LO = 16'hD800;
   localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
   localparam logic [15:0] LO_SUR_LO = 16'hDC00;
   localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   // One group of results caused by one input byte
   typedef struct packed {
      logic                              valid;
      logic [IdxW-1:0]                   last_idx;
      kind_type                          kind;
      logic [MaxResults-1:0][ByteW-1:0]  bytes;
   } grp_type;

   // Hex digit value; bit 4 set for a non-hex byte
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
      else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
      else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
      return v;
   endfunction

   // Single-result group
   function automatic grp_type one_result(input logic [7:0] b, input kind_type k);
      grp_type g;
      g          = '0;
      g.valid    = 1'b1;
      g.last_idx = '0;
      g.kind     = k;
      g.bytes[0] = b;
      return g;
   endfunction

   // UTF-8 encode a code point into 1 to 4 bytes
   function automatic grp_type encode_cp(input logic [20:0] cp);
      grp_type g;
      g       = '0;
      g.valid = 1'b1;
      g.kind  = KIND_BYTE;
      if (cp < 21'h80) begin
         g.last_idx = IdxW'(0);
         g.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         g.last_idx = IdxW'(1);
         g.bytes[0] = {3'b110, cp[10:6]};
         g.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         g.last_idx = IdxW'(2);
         g.bytes[0] = {4'b1110, cp[15:12]};
         g.bytes[1] = {2'b10, cp[11:6]};
         g.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         g.last_idx = IdxW'(3);
         g.bytes[0] = {5'b11110, cp[20:18]};
         g.bytes[1] = {2'b10, cp[17:12]};
         g.bytes[2] = {2'b10, cp[11:6]};
         g.bytes[3] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

endpackage

@@ src/json_string_unescape_utf8.sv @@
// Latency: first result of a byte is offered the cycle after the byte transfers.
// Throughput: one byte per cycle while each byte gives at most one result and rsp_tready
// is high; a byte that expands to n UTF-8 bytes holds the output register until its last result transfers.
// req_tready is high when the output register is empty or its last result transfers.
// Reset (synchronous, active high) returns the parser to waiting for the opening
// quote and empties the output register.
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);

   grp_type grp;
   logic    can_load;
   logic    take;

   assign req_tready = can_load;
   assign take       = req_tvalid && can_load;

   // Parser: state update and result group per byte
   jsu_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_take (take),
      .in_byte (req_tdata),
      .grp     (grp)
   );

   // Output register: one result per transfer
   jsu_out u_out (
      .clock      (clock),
      .reset      (reset),
      .grp        (grp),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ src/jsu_core.sv @@
module jsu_core
   import jsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_take,
   input  logic [7:0]    in_byte,
   output grp_type       grp
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] accum_ff, accum_in;
   logic        hex_bad_ff, hex_bad_in;
   logic [9:0]  high_ff, high_in;

   // Decode one byte: next state and result group
   always_comb begin
      logic [4:0]  d;
      logic        bad_n;
      logic [15:0] acc_n;
      logic [15:0] uc;
      logic        done;
      logic        as_body;
      logic        as_esc;

      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      accum_in     = accum_ff;
      hex_bad_in   = hex_bad_ff;
      high_in      = high_ff;
      grp          = '0;
      as_body      = 1'b0;
      as_esc       = 1'b0;

      // Hex position: any byte fills it
      d     = hex_value(in_byte);
      bad_n = hex_bad_ff | d[4];
      acc_n = d[4] ? accum_ff : {accum_ff[11:0], d[3:0]};
      done  = (hex_count_ff == 2'd3);
      uc    = bad_n ? 16'h0000 : acc_n;

      case (mode_ff)
         MODE_BODY: as_body = 1'b1;
         MODE_ESC:  as_esc  = 1'b1;
         MODE_HEX1: begin
            hex_bad_in   = bad_n;
            accum_in     = acc_n;
            hex_count_in = hex_count_ff + 2'd1;
            if (done) begin
               mode_in = MODE_BODY;
               if (uc == 16'h0000 || (uc >= LO_SUR_LO && uc <= LO_SUR_HI)) begin
                  grp = '0;
               end else if (uc >= HI_SUR_LO && uc <= HI_SUR_HI) begin
                  high_in = uc[9:0];
                  mode_in = MODE_PAIR_BS;
               end else begin
                  grp = encode_cp({5'd0, uc});
               end
            end
         end
         MODE_PAIR_BS: begin
            if (in_byte == CH_BSLASH) mode_in = MODE_PAIR_U;
            else as_body = 1'b1;
         end
         MODE_PAIR_U: begin
            if (in_byte == CH_U) begin
               mode_in      = MODE_HEX2;
               hex_count_in = 2'd0;
               accum_in     = '0;
               hex_bad_in   = 1'b0;
            end else begin
               as_esc = 1'b1;
            end
         end
         MODE_HEX2: begin
            hex_bad_in   = bad_n;
            accum_in     = acc_n;
            hex_count_in = hex_count_ff + 2'd1;
            if (done) begin
               mode_in = MODE_BODY;
               if (uc >= LO_SUR_LO && uc <= LO_SUR_HI) begin
                  grp = encode_cp(SUPP_BASE + {1'b0, high_ff, uc[9:0]});
               end
            end
         end
         default: begin
            // Waiting for the opening quote
            if (in_byte == CH_QUOTE) mode_in = MODE_BODY;
            else grp = one_result(8'h00, KIND_ERR);
         end
      endcase

      // Ordinary body byte
      if (as_body) begin
         mode_in = MODE_BODY;
         if (in_byte == CH_QUOTE || in_byte == CH_NUL) begin
            mode_in = MODE_WAIT;
            grp     = one_result(8'h00, KIND_END);
         end else if (in_byte == CH_BSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            grp = one_result(in_byte, KIND_BYTE);
         end
      end

      // Byte after a backslash
      if (as_esc) begin
         mode_in = MODE_BODY;
         case (in_byte)
            CH_B:    grp = one_result(8'h08, KIND_BYTE);
            CH_F:    grp = one_result(8'h0C, KIND_BYTE);
            CH_N:    grp = one_result(8'h0A, KIND_BYTE);
            CH_R:    grp = one_result(8'h0D, KIND_BYTE);
            CH_T:    grp = one_result(8'h09, KIND_BYTE);
            CH_U: begin
               mode_in      = MODE_HEX1;
               hex_count_in = 2'd0;
               accum_in     = '0;
               hex_bad_in   = 1'b0;
            end
            default: grp = one_result(in_byte, KIND_BYTE);
         endcase
      end

      if (!in_take) grp.valid = 1'b0;
   end

   // Advance parser state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         hex_count_ff <= '0;
         accum_ff     <= '0;
         hex_bad_ff   <= 1'b0;
         high_ff      <= '0;
      end else if (in_take) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         accum_ff     <= accum_in;
         hex_bad_ff   <= hex_bad_in;
         high_ff      <= high_in;
      end
   end

endmodule

@@ src/jsu_out.sv @@
module jsu_out
   import jsu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  grp_type           grp,
   output logic              can_load,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic                              valid_ff;
   logic [IdxW-1:0]                   idx_ff, idx_in;
   logic [IdxW-1:0]                   last_idx_ff;
   kind_type                          kind_ff;
   logic [MaxResults-1:0][ByteW-1:0]  bytes_ff;
   logic                              at_last;
   logic                              load;

   assign at_last    = (idx_ff == last_idx_ff);
   assign can_load   = !valid_ff || (rsp_tready && at_last);
   assign load       = grp.valid && can_load;
   assign idx_in     = idx_ff + IdxW'(1);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = at_last;

   // Control: hold the group until its last result transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_tready) begin
         if (at_last) valid_ff <= 1'b0;
         else idx_ff <= idx_in;
      end
   end

   // Payload: load a new group
   always_ff @(posedge clock) begin
      if (load) begin
         last_idx_ff <= grp.last_idx;
         kind_ff     <= grp.kind;
         bytes_ff    <= grp.bytes;
      end
   end

   // A group is never overwritten before its last result transfers
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      grp.valid |-> (!valid_ff || (rsp_tready && at_last)))
      else $error("result group overwritten");

   // End and error results stand alone
   a_single_status: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_BYTE) |-> (last_idx_ff == '0 && rsp_tdata == 8'h00))
      else $error("status result not single");

   // Index never runs past the group end
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= last_idx_ff))
      else $error("result index past group end");

   // Non-last transfer advances the index
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_tready && !at_last) |=> (idx_ff == $past(idx_ff) + IdxW'(1)))
      else $error("result index did not advance");

endmodule

@@ verif/tb_json_string_unescape_utf8.sv @@
module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Tracks the unescaper state and the UTF-8 results still owed by the block
   class unescape_scoreboard;
      typedef struct packed {
         logic [7:0] data;
         kind_type   kind;
         logic       last;
      } result_type;

      result_type expected_q[$];
      mode_type   mode;
      logic [1:0] digit_idx;
      logic [15:0] accum;
      logic       digit_bad;
      logic [9:0] hi_bits;
      int mismatches, inputs_seen, results_seen, ends_seen, quote_errs, wide_chars;

      function new();
         mode       = MODE_WAIT;
         digit_idx  = '0;
         accum      = '0;
         digit_bad  = 1'b0;
         hi_bits    = '0;
         mismatches = 0;
         inputs_seen = 0;
         results_seen = 0;
         ends_seen  = 0;
         quote_errs = 0;
         wide_chars = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void put(logic [7:0] d, kind_type k);
         result_type e;
         e.data = d;
         e.kind = k;
         e.last = 1'b0;
         expected_q.push_back(e);
      endfunction

      // Value of one hex position, bit 4 flags a non-hex byte
      function logic [4:0] digit_of(logic [7:0] b);
         if (b inside {[8'h30:8'h39]}) return {1'b0, b[3:0]};
         if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, b[3:0] + 4'd9};
         return 5'h10;
      endfunction

      // Take one hex position; report when the fourth one is in
      function logic take_digit(logic [7:0] b);
         logic [4:0] d;
         d = digit_of(b);
         if (d[4]) digit_bad = 1'b1;
         else accum = {accum[11:0], d[3:0]};
         if (digit_idx == 2'd3) begin
            digit_idx = '0;
            return 1'b1;
         end
         digit_idx = digit_idx + 2'd1;
         return 1'b0;
      endfunction

      function void start_digits(mode_type next_mode);
         mode      = next_mode;
         digit_idx = '0;
         accum     = '0;
         digit_bad = 1'b0;
      endfunction

      // Emit a code point as 1 to 4 UTF-8 bytes
      function void put_code(logic [20:0] cp);
         if (cp < 21'h80) begin
            put(cp[7:0], KIND_BYTE);
         end else begin
            wide_chars++;
            if (cp < 21'h800) begin
               put(8'hC0 | 8'(cp >> 6), KIND_BYTE);
               put(8'h80 | 8'(cp & 21'h3F), KIND_BYTE);
            end else if (cp < 21'h10000) begin
               put(8'hE0 | 8'(cp >> 12), KIND_BYTE);
               put(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_BYTE);
               put(8'h80 | 8'(cp & 21'h3F), KIND_BYTE);
            end else begin
               put(8'hF0 | 8'(cp >> 18), KIND_BYTE);
               put(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_BYTE);
               put(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_BYTE);
               put(8'h80 | 8'(cp & 21'h3F), KIND_BYTE);
            end
         end
      endfunction

      function void body_byte(logic [7:0] b);
         mode = MODE_BODY;
         if (b == CH_QUOTE || b == CH_NUL) begin
            mode = MODE_WAIT;
            ends_seen++;
            put(8'h00, KIND_END);
         end else if (b == CH_BSLASH) begin
            mode = MODE_ESC;
         end else begin
            put(b, KIND_BYTE);
         end
      endfunction

      function void escaped_byte(logic [7:0] b);
         mode = MODE_BODY;
         case (b)
            CH_B: put(8'h08, KIND_BYTE);
            CH_F: put(8'h0C, KIND_BYTE);
            CH_N: put(8'h0A, KIND_BYTE);
            CH_R: put(8'h0D, KIND_BYTE);
            CH_T: put(8'h09, KIND_BYTE);
            CH_U: start_digits(MODE_HEX1);
            default: put(b, KIND_BYTE);
         endcase
      endfunction

      // Predict the results of one transferred input byte
      function void note_input(logic [7:0] b);
         int      prior;
         logic [15:0] cu;
         result_type e;
         prior = expected_q.size();
         inputs_seen++;
         case (mode)
            MODE_BODY: body_byte(b);
            MODE_ESC:  escaped_byte(b);
            MODE_HEX1: begin
               if (take_digit(b)) begin
                  cu   = digit_bad ? 16'h0000 : accum;
                  mode = MODE_BODY;
                  if (cu == 16'h0000 || cu inside {[LO_SUR_LO:LO_SUR_HI]}) begin
                     // nothing for a null or an unpaired low half
                  end else if (cu inside {[HI_SUR_LO:HI_SUR_HI]}) begin
                     hi_bits = cu[9:0];
                     mode    = MODE_PAIR_BS;
                  end else begin
                     put_code({5'd0, cu});
                  end
               end
            end
            MODE_PAIR_BS: begin
               if (b == CH_BSLASH) mode = MODE_PAIR_U;
               else body_byte(b);
            end
            MODE_PAIR_U: begin
               if (b == CH_U) start_digits(MODE_HEX2);
               else escaped_byte(b);
            end
            MODE_HEX2: begin
               if (take_digit(b)) begin
                  cu   = digit_bad ? 16'h0000 : accum;
                  mode = MODE_BODY;
                  if (cu inside {[LO_SUR_LO:LO_SUR_HI]})
                     put_code(SUPP_BASE + {1'b0, hi_bits, cu[9:0]});
               end
            end
            default: begin
               if (b == CH_QUOTE) begin
                  mode = MODE_BODY;
               end else begin
                  quote_errs++;
                  put(8'h00, KIND_ERR);
               end
            end
         endcase
         // Flag the final result of this byte
         if (expected_q.size() > prior) begin
            e      = expected_q.pop_back();
            e.last = 1'b1;
            expected_q.push_back(e);
         end
      endfunction

      // Compare one transferred result with the oldest prediction
      function void check_result(logic [7:0] d, logic [1:0] k, logic l);
         result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte %h kind %0d last %b", d, k, l);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         results_seen++;
         if (d !== e.data) begin
            $error("out_byte: expected %h, got %h", e.data, d);
            mismatches++;
         end
         if (k !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, k);
            mismatches++;
         end
         if (l !== e.last) begin
            $error("last_of_run: expected %b, got %b", e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   unescape_scoreboard sb = new();
   logic       steady = 1'b0;   // both sides run without idling while set
   int         sent_count = 0;
   logic [7:0] text_q[$];       // bytes of the next string to send

   json_string_unescape_utf8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Transfer one byte after a random gap, or with no gap while steady is set
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_input(b);
      sent_count++;
   endtask

   // Hold off the sender until every predicted result has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // Append a \u escape, optionally with one position spoiled
   function automatic void add_uescape(logic [15:0] v, logic spoil);
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_U);
      for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(v[4*i +: 4]));
      if (spoil) text_q[text_q.size() - 1 - $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] low_half();
      return ($urandom_range(0, 3) == 0) ? LO_SUR_HI : 16'($urandom_range(16'hDC00, 16'hDFFF));
   endfunction

   function automatic logic [15:0] high_half();
      return ($urandom_range(0, 3) == 0) ? HI_SUR_HI : 16'($urandom_range(16'hD800, 16'hDBFF));
   endfunction

   // Append one code point escape from a random class
   function automatic void add_unicode();
      case ($urandom_range(0, 9))
         0: add_uescape(16'($urandom_range(1, 16'h7F)), 1'b0);
         1: add_uescape(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
         2: add_uescape($urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                             : 16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0);
         3: add_uescape(16'h0000, 1'b0);
         4: add_uescape(low_half(), 1'b0);
         5, 6: begin
            add_uescape(high_half(), 1'b0);
            add_uescape(low_half(), 1'b0);
         end
         7: begin
            // high half followed by something that breaks the pair
            add_uescape(high_half(), 1'b0);
            case ($urandom_range(0, 2))
               0: text_q.push_back(8'($urandom_range(0, 255)));
               1: begin
                  text_q.push_back(CH_BSLASH);
                  text_q.push_back(8'($urandom_range(0, 255)));
               end
               default: add_uescape(16'($urandom_range(0, 16'hDBFF)), 1'b0);
            endcase
         end
         8: add_uescape(16'($urandom), 1'b1);
         default: begin
            add_uescape(high_half(), 1'b0);
            add_uescape(low_half(), 1'b1);
         end
      endcase
   endfunction

   // Build one quoted string with random content into text_q
   function automatic void build_string();
      logic [7:0] b;
      logic [7:0] escs[8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BSLASH, "/"};
      text_q.delete();
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      text_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 12)) begin
         case ($urandom_range(0, 19)) inside
            [0:9]: begin
               do b = 8'($urandom_range(1, 255));
               while (b == CH_QUOTE || b == CH_BSLASH);
               text_q.push_back(b);
            end
            [10:13]: begin
               text_q.push_back(CH_BSLASH);
               text_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                          : escs[$urandom_range(0, 7)]);
            end
            [14:18]: add_unicode();
            default: text_q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      // occasionally leave a dangling backslash before the close
      if ($urandom_range(0, 9) == 0) text_q.push_back(CH_BSLASH);
      text_q.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_QUOTE);
   endfunction

   // Accept results with random stalls (none while steady is set) and check each one
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Main sequence
   initial begin
      logic [7:0] opening[$] = '{8'hFF, CH_QUOTE, 8'h01, CH_BSLASH, CH_T, CH_BSLASH, CH_NUL,
                                 CH_BSLASH, CH_U, "0", "0", "e", "9",
                                 CH_BSLASH, CH_U, "D", "8", "3", "D",
                                 CH_BSLASH, CH_U, "D", "E", "0", "0", CH_NUL};
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_byte(opening[i]);
      drain();

      while (sent_count < 530) begin
         build_string();
         steady = ($urandom_range(0, 3) == 0);
         foreach (text_q[i]) send_byte(text_q[i]);
         if ($urandom_range(0, 9) == 0) drain();
      end
      steady = 1'b0;

      // Let the last results arrive, then watch for strays
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d predicted results never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("Run covered %0d input bytes and %0d results checked.",
               sb.inputs_seen, sb.results_seen);
      $display("It closed %0d strings, raised %0d quote errors, decoded %0d wide code points.",
               sb.ends_seen, sb.quote_errs, sb.wide_chars);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
src/jsu_pkg.sv
src/jsu_core.sv
src/jsu_out.sv
src/json_string_unescape_utf8.sv
verif/tb_json_string_unescape_utf8.sv
